// ===== rtl/core/lfq_pkg.sv =====
package lfq_pkg;

  // number of qualified faults per address and their lane positions
  localparam int unsigned NUM_FAULTS     = 6;
  localparam int unsigned FAULT_AUTONOMY = 0;
  localparam int unsigned FAULT_BATTERY  = 1;
  localparam int unsigned FAULT_LAMP     = 2;
  localparam int unsigned FAULT_FUNC     = 3;
  localparam int unsigned FAULT_DUR      = 4;
  localparam int unsigned FAULT_LINK     = 5;

  // device type codes
  localparam logic [7:0] TYPE_EMERGENCY = 8'h01;
  localparam logic [7:0] TYPE_LED       = 8'h06;

  // item kinds
  localparam logic MODE_STATUS = 1'b0;
  localparam logic MODE_LINK   = 1'b1;

  // per-fault qualifier state
  typedef enum logic [1:0] {
    Q_UNMARKED = 2'd0,
    Q_DETECTED = 2'd1,
    Q_MARKED   = 2'd2,
    Q_CLEARING = 2'd3
  } qual_t;

  // one stored row: all qualifiers of one address
  typedef qual_t [NUM_FAULTS-1:0] qual_row_t;

  typedef struct packed {
    qual_t next_q;
    logic  logged;
  } qual_step_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_UPDATE
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic fetch;
    logic update;
  } lfq_cmd_t;

  // advance one qualifier on a fault or clear report
  function automatic qual_step_t qualify(input qual_t cur, input logic fault,
                                         input logic accept);
    qual_step_t r;
    r.next_q = cur;
    r.logged = 1'b0;
    if (fault) begin
      if (cur == Q_UNMARKED) begin
        r.next_q = Q_DETECTED;
      end else if (cur == Q_DETECTED) begin
        if (accept) begin
          r.next_q = Q_MARKED;
          r.logged = 1'b1;
        end
      end else if (cur == Q_CLEARING) begin
        r.next_q = Q_MARKED;
      end
    end else begin
      if (cur == Q_MARKED) begin
        r.next_q = Q_CLEARING;
      end else begin
        r.next_q = Q_UNMARKED;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lfq_ctrl.sv =====
module lfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output lfq_pkg::lfq_cmd_t cmd
);

  lfq_pkg::ctrl_state_t state;
  lfq_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state: accept, read the row, write it back
  always_comb begin
    state_next = state;
    unique case (state)
      lfq_pkg::S_IDLE: begin
        if (start) begin
          state_next = lfq_pkg::S_FETCH;
        end
      end
      lfq_pkg::S_FETCH:  state_next = lfq_pkg::S_UPDATE;
      lfq_pkg::S_UPDATE: state_next = lfq_pkg::S_IDLE;
      default:           state_next = lfq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      lfq_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      lfq_pkg::S_FETCH:  cmd.fetch  = 1'b1;
      lfq_pkg::S_UPDATE: cmd.update = 1'b1;
      default:           busy       = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/lfq_datapath.sv =====
module lfq_datapath #(
  parameter int unsigned NUM_ADDRESSES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  lfq_pkg::lfq_cmd_t cmd,
  input  logic              mode,
  input  logic [5:0]        address,
  input  logic [7:0]        device_type,
  input  logic [7:0]        status_byte,
  input  logic              comm_failed,
  input  logic              log_accept,
  output logic              done,
  output logic [5:0]        address_out,
  output logic [5:0]        logged_mask,
  output logic [5:0]        marked_mask
);

  localparam int unsigned AW = (NUM_ADDRESSES > 1) ? $clog2(NUM_ADDRESSES) : 1;
  localparam int unsigned NF = lfq_pkg::NUM_FAULTS;

  // captured item
  logic       mode_r;
  logic [5:0] addr_r;
  logic [7:0] type_r;
  logic [7:0] status_r;
  logic       failed_r;
  logic       accept_r;
  logic       in_range;

  logic [8:0]    addr_ext;
  logic [AW-1:0] idx;

  // qualifier memory and per-row valid bits
  lfq_pkg::qual_row_t             mem [NUM_ADDRESSES];
  logic [NUM_ADDRESSES-1:0]       row_valid;
  lfq_pkg::qual_row_t             rd_row;
  logic                           rd_valid;

  lfq_pkg::qual_row_t cur_row;
  lfq_pkg::qual_row_t row_next;
  logic [NF-1:0]      fault_vec;
  logic [NF-1:0]      step_en;
  logic [NF-1:0]      logged_next;
  logic [NF-1:0]      marked_next;
  lfq_pkg::qual_step_t step [NF];

  // capture the item on accept
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode;
      addr_r   <= address;
      type_r   <= device_type;
      status_r <= status_byte;
      failed_r <= comm_failed;
      accept_r <= log_accept;
      in_range <= ({3'b000, address} < 9'(NUM_ADDRESSES));
    end
  end

  assign addr_ext = {3'b000, addr_r};
  assign idx      = addr_ext[AW-1:0];

  // registered row read
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_row   <= mem[idx];
      rd_valid <= row_valid[idx];
    end
  end

  // row write back
  always_ff @(posedge clk) begin
    if (cmd.update && in_range) begin
      mem[idx] <= row_next;
    end
  end

  // valid bits: a row never written reads as all unmarked
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.update && in_range) begin
      row_valid[idx] <= 1'b1;
    end
  end

  assign cur_row = rd_valid ? rd_row : lfq_pkg::qual_row_t'{default: lfq_pkg::Q_UNMARKED};

  // select which qualifiers this item steps and their fault inputs
  always_comb begin
    fault_vec = '0;
    step_en   = '0;
    if (mode_r == lfq_pkg::MODE_LINK) begin
      step_en[lfq_pkg::FAULT_LINK]   = 1'b1;
      fault_vec[lfq_pkg::FAULT_LINK] = failed_r;
    end else if (type_r == lfq_pkg::TYPE_EMERGENCY) begin
      step_en[lfq_pkg::FAULT_DUR:lfq_pkg::FAULT_AUTONOMY]   = 5'b11111;
      fault_vec[lfq_pkg::FAULT_DUR:lfq_pkg::FAULT_AUTONOMY] = status_r[5:1];
    end else if (type_r == lfq_pkg::TYPE_LED) begin
      step_en[lfq_pkg::FAULT_LAMP]   = 1'b1;
      fault_vec[lfq_pkg::FAULT_LAMP] = status_r[1];
    end
  end

  // qualifier lanes
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      step[i] = lfq_pkg::qualify(cur_row[i], fault_vec[i], accept_r);
      if (step_en[i]) begin
        row_next[i]    = step[i].next_q;
        logged_next[i] = step[i].logged & in_range;
      end else begin
        row_next[i]    = cur_row[i];
        logged_next[i] = 1'b0;
      end
      marked_next[i] = (row_next[i] == lfq_pkg::Q_MARKED) && in_range;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      address_out <= addr_r;
      logged_mask <= logged_next;
      marked_mask <= marked_next;
    end
  end

endmodule

// ===== rtl/core/luminaire_fault_qualifier.sv =====
// each item passes through capture, row read, qualify and write-back; a result
// shows on done after its write-back, and busy holds off a new start beat until
// the pass over the single-port qualifier memory is done
// reset: synchronous; all qualifiers of all addresses read as unmarked after
// reset, and the receiver cannot stall, so done lasts exactly one cycle
module luminaire_fault_qualifier #(
  parameter int unsigned NUM_ADDRESSES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [5:0] address,
  input  logic [7:0] device_type,
  input  logic [7:0] status_byte,
  input  logic       comm_failed,
  input  logic       log_accept,
  output logic       done,
  output logic [5:0] address_out,
  output logic [5:0] logged_mask,
  output logic [5:0] marked_mask
);

  lfq_pkg::lfq_cmd_t cmd;

  // sequencer
  lfq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // qualifier storage and update
  lfq_datapath #(
    .NUM_ADDRESSES (NUM_ADDRESSES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .address     (address),
    .device_type (device_type),
    .status_byte (status_byte),
    .comm_failed (comm_failed),
    .log_accept  (log_accept),
    .done        (done),
    .address_out (address_out),
    .logged_mask (logged_mask),
    .marked_mask (marked_mask)
  );

  // a result only follows a write-back
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.update))
    else $error("result without write-back");

  // an accepted beat makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a logged fault is marked in the same result
  a_logged_is_marked: assert property (@(posedge clk) disable iff (rst)
    done |-> ((logged_mask & ~marked_mask) == 6'd0))
    else $error("logged fault not marked");

  // one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.fetch, cmd.update}))
    else $error("overlapping datapath commands");

endmodule
